// File: hdl/triangle_unit_normal_assert.svh
// Assertion macros used by the triangle normal top-level RTL
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// Checked outside reset only
`define TUN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define TUN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/tun_pkg.sv
// Types, widths and a helper function for the triangle normal pipeline
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 14;
  localparam int NormTop   = 30;

  localparam int EdgeW = CoordBits + 1;
  localparam int ProdW = 2 * EdgeW;
  localparam int MagW  = 2 * CoordBits + 3;
  localparam int PosW  = $clog2(MagW);
  localparam int ShW   = MagW + NormTop;
  localparam int NormW = NormTop + 1;
  localparam int SqW   = 2 * NormW;
  localparam int SumW  = SqW + 2;
  localparam int RootW = SumW / 2;
  localparam int RemW  = RootW + 2;
  localparam int SqrtStages = RootW / 2;
  localparam int QuotW = FracBits + 1;
  localparam int NumW  = RootW + FracBits;
  localparam int OutW  = FracBits + 2;

  localparam logic signed [OutW-1:0] OneQ = OutW'(1) << FracBits;

  typedef struct packed {
    logic signed [CoordBits-1:0] a_x;
    logic signed [CoordBits-1:0] a_y;
    logic signed [CoordBits-1:0] a_z;
    logic signed [CoordBits-1:0] b_x;
    logic signed [CoordBits-1:0] b_y;
    logic signed [CoordBits-1:0] b_z;
    logic signed [CoordBits-1:0] c_x;
    logic signed [CoordBits-1:0] c_y;
    logic signed [CoordBits-1:0] c_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } tri_out_t;

  // cross product as sign and magnitude
  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
  } cross_t;

  // normalised components that ride alongside the root
  typedef struct packed {
    logic [2:0][NormW-1:0] mag;
    logic [2:0]            neg;
    logic                  deg;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [SumW-1:0] sum;
  } sq_t;

  typedef struct packed {
    side_t            side;
    logic [RootW-1:0] root;
  } root_t;

  typedef struct packed {
    logic [2:0][QuotW-1:0] q;
    logic [2:0]            neg;
    logic                  deg;
  } quo_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_acc_t;

  // one digit of the restoring square root
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    sqrt_acc_t       res;
    cur   = {acc.rem[RemW-3:0], pair};
    trial = {acc.root, 2'b01};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {acc.root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {acc.root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hdl/triangle_unit_normal.sv
// Unit face normal of one triangle per item, fully pipelined
// Input channel in_valid_i/in_ready_o carries three vertices (in_i); output
// channel out_valid_o/out_ready_i carries the Q1.14 unit normal and a
// degenerate flag (out_o). An item is taken when valid and ready are high.
// From acceptance to out_o an item passes edges and cross product,
// normalise and sum of squares, the square root (two root bits per
// stage), the three dividers (a numerator stage, then one quotient bit
// per stage) and the output register. Throughput is one item per cycle
// while the receiver does not stall; every stage is its own register.
// A degenerate triangle (zero cross product) gives a zero normal with the
// degenerate flag set.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated. in_ready_o is high
// whenever the output register is empty or being taken.
// Reset clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_unit_normal_assert.svh"

module triangle_unit_normal (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tun_pkg::tri_in_t  in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tun_pkg::tri_out_t      out_o
);
  import tun_pkg::*;

  logic     en;
  logic     cr_v;
  cross_t   cr_data;
  logic     nm_v;
  sq_t      nm_data;
  logic     sr_v;
  root_t    sr_data;
  logic     dv_v;
  quo_t     dv_data;
  logic     out_valid_q;
  tri_out_t out_d;
  tri_out_t out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  tun_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_i),
    .valid_o (cr_v),
    .data_o  (cr_data)
  );

  tun_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cr_v),
    .data_i  (cr_data),
    .valid_o (nm_v),
    .data_o  (nm_data)
  );

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_v),
    .data_i  (nm_data),
    .valid_o (sr_v),
    .data_o  (sr_data)
  );

  tun_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sr_v),
    .data_i  (sr_data),
    .valid_o (dv_v),
    .data_o  (dv_data)
  );

  always_comb begin
    logic [OutW-1:0] m [3];
    logic [OutW-1:0] f [3];
    for (int i = 0; i < 3; i++) begin
      m[i] = OutW'(dv_data.q[i]);
      if (dv_data.deg) begin
        f[i] = '0;
      end else if (dv_data.neg[i]) begin
        f[i] = ~m[i] + OutW'(1);
      end else begin
        f[i] = m[i];
      end
    end
    out_d.normal_x   = f[0];
    out_d.normal_y   = f[1];
    out_d.normal_z   = f[2];
    out_d.degenerate = dv_data.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `TUN_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> in_ready_o, "pipeline stalled with empty output")
  `TUN_ASSERT(a_deg_zero, out_valid_o && out_o.degenerate |-> out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0, "degenerate item with non-zero normal")
  `TUN_ASSERT(a_range, out_valid_o && !out_o.degenerate |-> out_o.normal_x <= OneQ && out_o.normal_x >= -OneQ && out_o.normal_y <= OneQ && out_o.normal_y >= -OneQ && out_o.normal_z <= OneQ && out_o.normal_z >= -OneQ, "normal component beyond unit range")
  `TUN_ASSERT(a_nonzero, out_valid_o && !out_o.degenerate |-> out_o.normal_x != '0 || out_o.normal_y != '0 || out_o.normal_z != '0, "zero normal on a proper triangle")

endmodule

`default_nettype wire

// File: hdl/tun_cross.sv
// Edge vectors, cross product and sign/magnitude split, four stages
`timescale 1ns / 1ps
`default_nettype none

module tun_cross (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire tun_pkg::tri_in_t data_i,
  output logic                 valid_o,
  output tun_pkg::cross_t      data_o
);
  import tun_pkg::*;

  logic [3:0] v_q;

  logic signed [EdgeW-1:0] e0_d [3];
  logic signed [EdgeW-1:0] e1_d [3];
  logic signed [EdgeW-1:0] e0_q [3];
  logic signed [EdgeW-1:0] e1_q [3];
  logic signed [ProdW-1:0] p_d [6];
  logic signed [ProdW-1:0] p_q [6];
  logic signed [MagW-1:0]  n_d [3];
  logic signed [MagW-1:0]  n_q [3];
  cross_t                  c_d;
  cross_t                  c_q;

  always_comb begin
    e0_d[0] = EdgeW'(data_i.b_x) - EdgeW'(data_i.a_x);
    e0_d[1] = EdgeW'(data_i.b_y) - EdgeW'(data_i.a_y);
    e0_d[2] = EdgeW'(data_i.b_z) - EdgeW'(data_i.a_z);
    e1_d[0] = EdgeW'(data_i.c_x) - EdgeW'(data_i.a_x);
    e1_d[1] = EdgeW'(data_i.c_y) - EdgeW'(data_i.a_y);
    e1_d[2] = EdgeW'(data_i.c_z) - EdgeW'(data_i.a_z);

    p_d[0] = ProdW'(e0_q[1]) * ProdW'(e1_q[2]);
    p_d[1] = ProdW'(e0_q[2]) * ProdW'(e1_q[1]);
    p_d[2] = ProdW'(e0_q[2]) * ProdW'(e1_q[0]);
    p_d[3] = ProdW'(e0_q[0]) * ProdW'(e1_q[2]);
    p_d[4] = ProdW'(e0_q[0]) * ProdW'(e1_q[1]);
    p_d[5] = ProdW'(e0_q[1]) * ProdW'(e1_q[0]);

    for (int i = 0; i < 3; i++) begin
      n_d[i] = MagW'(p_q[2*i]) - MagW'(p_q[2*i+1]);
      c_d.neg[i] = n_q[i][MagW-1];
      c_d.mag[i] = n_q[i][MagW-1] ? MagW'(-n_q[i]) : MagW'(n_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q <= e0_d;
      e1_q <= e1_d;
      p_q  <= p_d;
      n_q  <= n_d;
      c_q  <= c_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = c_q;

endmodule

`default_nettype wire

// File: hdl/tun_norm.sv
// Leading-one search, common shift, squares and their sum, four stages
`timescale 1ns / 1ps
`default_nettype none

module tun_norm (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire tun_pkg::cross_t data_i,
  output logic                valid_o,
  output tun_pkg::sq_t        data_o
);
  import tun_pkg::*;

  logic [3:0] v_q;

  logic [MagW-1:0] orv;
  logic [PosW-1:0] pos_d;
  logic [PosW-1:0] pos_q;
  cross_t          c_q;
  logic            deg_d;
  logic            deg_q;
  side_t           sh_d;
  side_t           sh_q;
  logic [ShW-1:0]  wide;
  logic [SqW-1:0]  sqr_d [3];
  logic [SqW-1:0]  sqr_q [3];
  side_t           sqs_q;
  sq_t             sum_d;
  sq_t             sum_q;

  always_comb begin
    // the top one of the OR is the top one of the largest magnitude
    orv   = data_i.mag[0] | data_i.mag[1] | data_i.mag[2];
    deg_d = (orv == '0);
    pos_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orv[i]) pos_d = PosW'(i);
    end

    sh_d.neg = c_q.neg;
    sh_d.deg = deg_q;
    for (int i = 0; i < 3; i++) begin
      wide = (ShW'(c_q.mag[i]) << NormTop) >> pos_q;
      sh_d.mag[i] = wide[NormW-1:0];
    end

    for (int i = 0; i < 3; i++) begin
      sqr_d[i] = SqW'(sh_q.mag[i]) * SqW'(sh_q.mag[i]);
    end

    sum_d.side = sqs_q;
    sum_d.sum  = SumW'(sqr_q[0]) + SumW'(sqr_q[1]) + SumW'(sqr_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= data_i;
      pos_q <= pos_d;
      deg_q <= deg_d;
      sh_q  <= sh_d;
      sqr_q <= sqr_d;
      sqs_q <= sh_q;
      sum_q <= sum_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = sum_q;

endmodule

`default_nettype wire

// File: hdl/tun_sqrt.sv
// Pipelined restoring integer square root, two root bits per stage
`timescale 1ns / 1ps
`default_nettype none

module tun_sqrt (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire tun_pkg::sq_t data_i,
  output logic              valid_o,
  output tun_pkg::root_t    data_o
);
  import tun_pkg::*;

  logic [SqrtStages-1:0] v_q;

  logic [SumW-1:0] s_d   [SqrtStages];
  logic [SumW-1:0] s_q   [SqrtStages];
  sqrt_acc_t       acc_d [SqrtStages];
  sqrt_acc_t       acc_q [SqrtStages];
  side_t           sd_d  [SqrtStages];
  side_t           sd_q  [SqrtStages];

  always_comb begin
    logic [SumW-1:0] src_s;
    sqrt_acc_t       src_acc;
    sqrt_acc_t       mid;
    for (int k = 0; k < SqrtStages; k++) begin
      if (k == 0) begin
        src_s   = data_i.sum;
        src_acc = '0;
        sd_d[k] = data_i.side;
      end else begin
        src_s   = s_q[k-1];
        src_acc = acc_q[k-1];
        sd_d[k] = sd_q[k-1];
      end
      mid      = sqrt_step(src_acc, src_s[SumW-1 -: 2]);
      acc_d[k] = sqrt_step(mid, src_s[SumW-3 -: 2]);
      s_d[k]   = src_s << 4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SqrtStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= s_d;
      acc_q <= acc_d;
      sd_q  <= sd_d;
    end
  end

  assign valid_o     = v_q[SqrtStages-1];
  assign data_o.side = sd_q[SqrtStages-1];
  assign data_o.root = acc_q[SqrtStages-1].root;

endmodule

`default_nettype wire

// File: hdl/tun_div.sv
// Rounded quotients mag/root for three lanes, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module tun_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire tun_pkg::root_t data_i,
  output logic                valid_o,
  output tun_pkg::quo_t       data_o
);
  import tun_pkg::*;

  logic                  nv_q;
  logic [QuotW-1:0]      v_q;

  logic [2:0][NumW-1:0]  num_d;
  logic [2:0][NumW-1:0]  num_q;
  logic [RootW-1:0]      nr_q;
  logic [2:0]            nneg_q;
  logic                  ndeg_q;

  logic [2:0][NumW-1:0]  rem_d [QuotW];
  logic [2:0][NumW-1:0]  rem_q [QuotW];
  logic [2:0][QuotW-1:0] q_d   [QuotW];
  logic [2:0][QuotW-1:0] q_q   [QuotW];
  logic [RootW-1:0]      r_q   [QuotW];
  logic [2:0]            neg_q [QuotW];
  logic                  deg_q [QuotW];
  logic [RootW-1:0]      r_d   [QuotW];
  logic [2:0]            neg_d [QuotW];
  logic                  deg_d [QuotW];

  always_comb begin
    logic [2:0][NumW-1:0]  src_rem;
    logic [2:0][QuotW-1:0] src_q;
    logic [NumW-1:0]       dvs;
    // numerator is mag scaled to Q.FracBits plus half the root
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NumW'(data_i.side.mag[i]) << FracBits) + NumW'(data_i.root >> 1);
    end

    for (int j = 0; j < QuotW; j++) begin
      if (j == 0) begin
        src_rem  = num_q;
        src_q    = '0;
        r_d[j]   = nr_q;
        neg_d[j] = nneg_q;
        deg_d[j] = ndeg_q;
      end else begin
        src_rem  = rem_q[j-1];
        src_q    = q_q[j-1];
        r_d[j]   = r_q[j-1];
        neg_d[j] = neg_q[j-1];
        deg_d[j] = deg_q[j-1];
      end
      dvs = NumW'(r_d[j]) << (QuotW - 1 - j);
      for (int i = 0; i < 3; i++) begin
        if (src_rem[i] >= dvs) begin
          rem_d[j][i] = src_rem[i] - dvs;
          q_d[j][i]   = {src_q[i][QuotW-2:0], 1'b1};
        end else begin
          rem_d[j][i] = src_rem[i];
          q_d[j][i]   = {src_q[i][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
      v_q  <= '0;
    end else if (en_i) begin
      nv_q <= valid_i;
      v_q  <= {v_q[QuotW-2:0], nv_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      nr_q   <= data_i.root;
      nneg_q <= data_i.side.neg;
      ndeg_q <= data_i.side.deg;
      rem_q  <= rem_d;
      q_q    <= q_d;
      r_q    <= r_d;
      neg_q  <= neg_d;
      deg_q  <= deg_d;
    end
  end

  assign valid_o    = v_q[QuotW-1];
  assign data_o.q   = q_q[QuotW-1];
  assign data_o.neg = neg_q[QuotW-1];
  assign data_o.deg = deg_q[QuotW-1];

endmodule

`default_nettype wire

// File: tb/triangle_unit_normal_tb.sv
// Self-checking testbench for the triangle unit normal pipeline
`timescale 1ns / 1ps

module triangle_unit_normal_tb;
  import tun_pkg::*;

  localparam int TriBits    = $bits(tri_in_t);
  localparam int HoldCycles = 150;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  tri_in_t  in_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  tri_out_t out_o;

  triangle_unit_normal u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o)
  );

  tri_in_t  tri_pending[$];
  tri_out_t normal_expected[$];
  int       mismatches = 0;
  int       send_idle_pct = 27;
  int       recv_idle_pct = 86;
  int       hold_cnt = 0;
  bit       hold_go = 1'b0;
  bit       send_pause = 1'b0;

  initial forever #2 clk_i = ~clk_i;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic tri_out_t face_normal(tri_in_t t);
    longint   e0x, e0y, e0z, e1x, e1y, e1z;
    longint   n[3];
    logic [63:0] mag[3];
    logic [63:0] m, s, r, q;
    bit       neg[3];
    int       p;
    logic [OutW-1:0] f[3];
    tri_out_t o;
    e0x = longint'(t.b_x) - longint'(t.a_x);
    e0y = longint'(t.b_y) - longint'(t.a_y);
    e0z = longint'(t.b_z) - longint'(t.a_z);
    e1x = longint'(t.c_x) - longint'(t.a_x);
    e1y = longint'(t.c_y) - longint'(t.a_y);
    e1z = longint'(t.c_z) - longint'(t.a_z);
    n[0] = e0y * e1z - e0z * e1y;
    n[1] = e0z * e1x - e0x * e1z;
    n[2] = e0x * e1y - e0y * e1x;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = n[i] < 0;
      mag[i] = neg[i] ? 64'(-n[i]) : 64'(n[i]);
      if (mag[i] > m) m = mag[i];
    end
    o = '0;
    if (m == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    p = 0;
    while ((m >> p) > 1) p++;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (p < NormTop) mag[i] = mag[i] << (NormTop - p);
      else if (p > NormTop) mag[i] = mag[i] >> (p - NormTop);
      s = s + mag[i] * mag[i];
    end
    r = isqrt64(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FracBits) + (r >> 1)) / r;
      f[i] = neg[i] ? OutW'(-q) : OutW'(q);
    end
    o.normal_x = f[0];
    o.normal_y = f[1];
    o.normal_z = f[2];
    return o;
  endfunction

  task automatic queue_tri(tri_in_t t);
    tri_pending = {tri_pending, t};
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (tri_pending.size() > 0 && !send_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          normal_expected = {normal_expected, face_normal(tri_pending[0])};
          in_i <= tri_pending.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with one long hold-off once requested
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt < HoldCycles) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tri_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (normal_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", out_o);
      end else begin
        want = normal_expected.pop_front();
        if (out_o.normal_x !== want.normal_x || out_o.normal_y !== want.normal_y ||
            out_o.normal_z !== want.normal_z || out_o.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_o);
        end
      end
    end
  end

  function automatic tri_in_t rand_tri();
    tri_in_t t;
    t = TriBits'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(5))
      0: begin t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z; end
      1: begin  // collinear: c = a + 2(b - a) along small edge
        t.b_x = t.a_x + 16'($signed($urandom_range(15)) - 7);
        t.b_y = t.a_y + 16'($signed($urandom_range(15)) - 7);
        t.b_z = t.a_z + 16'($signed($urandom_range(15)) - 7);
        t.c_x = t.a_x + 16'(2 * (t.b_x - t.a_x));
        t.c_y = t.a_y + 16'(2 * (t.b_y - t.a_y));
        t.c_z = t.a_z + 16'(2 * (t.b_z - t.a_z));
      end
      2: begin  // small triangle near a
        t.b_x = t.a_x + 16'($urandom_range(3)); t.b_y = t.a_y + 16'($urandom_range(3));
        t.b_z = t.a_z + 16'($urandom_range(3)); t.c_x = t.a_x + 16'($urandom_range(3));
        t.c_y = t.a_y + 16'($urandom_range(3)); t.c_z = t.a_z + 16'($urandom_range(3));
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic drain();
    while (tri_pending.size() > 0 || normal_expected.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    tri_in_t t;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, axis-aligned faces, degenerate cases, ties
    queue_tri('0);
    t = '0; t.b_x = 1; t.c_y = 1; queue_tri(t);
    t = '0; t.b_y = 1; t.c_z = 1; queue_tri(t);
    t = '0; t.b_z = 1; t.c_x = 1; queue_tri(t);
    t = '0; t.b_x = 1; t.c_x = -1; queue_tri(t);
    t = '0; t.b_x = 3; t.c_y = 4; t.c_z = 5; queue_tri(t);
    t = '1; queue_tri(t);
    t = '0; t.a_x = -32768; t.a_y = -32768; t.a_z = -32768;
    t.b_x = 32767; t.b_y = -32768; t.b_z = -32768;
    t.c_x = -32768; t.c_y = 32767; t.c_z = 32767; queue_tri(t);
    t = '0; t.a_x = 32767; t.a_y = 32767; t.a_z = 32767;
    t.b_x = -32768; t.b_y = 32767; t.b_z = 32767;
    t.c_x = 32767; t.c_y = -32768; t.c_z = 32767; queue_tri(t);
    t = '0; t.a_x = -32768; t.b_y = -32768; t.c_z = -32768; queue_tri(t);
    t = '0; t.a_x = 32767; t.b_y = 32767; t.c_z = 32767; queue_tri(t);
    t = '0; t.b_x = 1; t.b_y = 1; t.c_x = 1; t.c_z = 1; queue_tri(t);
    t = '0; t.b_x = 32767; t.c_y = 1; queue_tri(t);
    t = '0; t.b_x = 1; t.b_y = 2; t.c_x = 2; t.c_y = 1; t.c_z = 7; queue_tri(t);
    for (int i = 0; i < 200; i++) queue_tri(rand_tri());
    drain();
    // receiver stalls for a long stretch while the sender keeps offering
    send_idle_pct = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 100; i++) queue_tri(rand_tri());
    drain();
    send_idle_pct = 86; recv_idle_pct = 27;
    for (int i = 0; i < 180; i++) queue_tri(rand_tri());
    // sender pauses until every result is back
    while (tri_pending.size() > 60) @(posedge clk_i);
    send_pause = 1'b1;
    while (normal_expected.size() > 0 || in_valid_i) @(posedge clk_i);
    send_pause = 1'b0;
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 170; i++) queue_tri(rand_tri());
    drain();
    if (mismatches == 0 && normal_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
